FILE: rtl/core/rfd_pkg.sv
// shared constants, status codes and crc helper for the record frame decoder
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

    // frame geometry
    localparam int FRAME_LENGTH_DEF = 38;
    localparam int COUNT_W          = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
    localparam logic [COUNT_W-1:0] CRC_SPAN  = 6'd36;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_MAGIC    = 2'd0;
    localparam logic [1:0] CFG_SCHEMA_VERSION = 2'd1;
    localparam logic [1:0] CFG_SOURCE_LIMIT   = 2'd2;

    localparam logic [16:0] SOURCE_LIMIT_RST = 17'h10000;

    // result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_TRUNCATED = 3'd1;
    localparam t_status ST_BAD_MAGIC = 3'd2;
    localparam t_status ST_BAD_VER   = 3'd3;
    localparam t_status ST_BAD_SRC   = 3'd4;
    localparam t_status ST_BAD_CRC   = 3'd5;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/record_frame_decoder_unit.sv
// record frame decoder: byte-stream parser of a crc-16 protected record frame
//
// Takes one buffer byte per cycle, with the last byte marked, and on the
// marked byte returns one status word plus the decoded record (record fields
// are zero unless the status is ok). A byte is accepted in every cycle while
// the result side keeps up: each byte passes an input register and the
// byte-wide crc and field capture logic, and the last one lands in the
// result register, which then presents the result as valid. The input side
// stalls only when a finished result is still held and another last byte is
// waiting behind it. Configuration writes are always ready and must be made
// while no buffer is in flight.
`timescale 1ns / 1ps
`default_nettype none

module record_frame_decoder_unit
    import rfd_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // byte input
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_end_of_buffer,
    // result output
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [2:0]              o_status,
    output logic [15:0]             o_origin_id,
    output logic [31:0]             o_sequence_number,
    output logic signed [63:0]      o_time_ns,
    output logic signed [31:0]      o_position_x,
    output logic signed [31:0]      o_position_y,
    output logic signed [31:0]      o_velocity_x,
    output logic signed [31:0]      o_velocity_y,
    // configuration
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [16:0]        i_cfg_data
);

    localparam logic [COUNT_W-1:0] FRAME_LEN = COUNT_W'(FRAME_LENGTH);

    // configuration registers
    logic [15:0] r_frame_magic;
    logic [15:0] r_schema_version;
    logic [16:0] r_source_limit;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // frame state
    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]        r_running_crc, n_running_crc;
    logic [7:0]         r_high_hold, n_high_hold;
    logic               r_magic_bad, n_magic_bad;
    logic               r_version_bad, n_version_bad;
    logic [15:0]        r_source_word, n_source_word;
    logic [31:0]        r_seq_word, n_seq_word;
    logic [63:0]        r_time_word, n_time_word;
    logic [31:0]        r_pos_x, n_pos_x;
    logic [31:0]        r_pos_y, n_pos_y;
    logic [31:0]        r_vel_x, n_vel_x;
    logic [31:0]        r_vel_y, n_vel_y;
    logic [15:0]        r_rx_crc, n_rx_crc;

    // result register
    logic        r_out_valid;
    t_status     r_status;
    logic [15:0] r_out_source;
    logic [31:0] r_out_seq;
    logic [63:0] r_out_time;
    logic [31:0] r_out_pos_x;
    logic [31:0] r_out_pos_y;
    logic [31:0] r_out_vel_x;
    logic [31:0] r_out_vel_y;

    logic        blocked;
    logic        fire;
    logic [COUNT_W-1:0] idx;
    t_status     n_status;

    // a held result only blocks a byte that would produce another one
    assign blocked    = r_in_valid && r_in_last && r_out_valid && i_out_stall;
    assign fire       = r_in_valid && !blocked;
    assign o_in_stall = blocked;
    assign o_cfg_ready = 1'b1;
    assign idx        = r_byte_count;

    always_comb begin
        n_byte_count  = r_byte_count;
        n_running_crc = r_running_crc;
        n_high_hold   = r_high_hold;
        n_magic_bad   = r_magic_bad;
        n_version_bad = r_version_bad;
        n_source_word = r_source_word;
        n_seq_word    = r_seq_word;
        n_time_word   = r_time_word;
        n_pos_x       = r_pos_x;
        n_pos_y       = r_pos_y;
        n_vel_x       = r_vel_x;
        n_vel_y       = r_vel_y;
        n_rx_crc      = r_rx_crc;

        if (idx < FRAME_LEN) begin
            if (idx < CRC_SPAN) begin
                n_running_crc = crc_byte(r_running_crc, r_in_byte);
            end
            if (idx == 6'd0 || idx == 6'd2) begin
                n_high_hold = r_in_byte;
            end else if (idx == 6'd1) begin
                n_magic_bad = ({r_high_hold, r_in_byte} != r_frame_magic);
            end else if (idx == 6'd3) begin
                n_version_bad = ({r_high_hold, r_in_byte} != r_schema_version);
            end else if (idx == 6'd4 || idx == 6'd5) begin
                n_source_word = {r_source_word[7:0], r_in_byte};
            end else if (idx >= 6'd8 && idx <= 6'd11) begin
                n_seq_word = {r_seq_word[23:0], r_in_byte};
            end else if (idx >= 6'd12 && idx <= 6'd19) begin
                n_time_word = {r_time_word[55:0], r_in_byte};
            end else if (idx >= 6'd20 && idx <= 6'd23) begin
                n_pos_x = {r_pos_x[23:0], r_in_byte};
            end else if (idx >= 6'd24 && idx <= 6'd27) begin
                n_pos_y = {r_pos_y[23:0], r_in_byte};
            end else if (idx >= 6'd28 && idx <= 6'd31) begin
                n_vel_x = {r_vel_x[23:0], r_in_byte};
            end else if (idx >= 6'd32 && idx <= 6'd35) begin
                n_vel_y = {r_vel_y[23:0], r_in_byte};
            end else if (idx == 6'd36 || idx == 6'd37) begin
                n_rx_crc = {r_rx_crc[7:0], r_in_byte};
            end
        end

        if (idx < COUNT_MAX) begin
            n_byte_count = idx + 6'd1;
        end

        // checks in priority order
        if (n_byte_count < FRAME_LEN) begin
            n_status = ST_TRUNCATED;
        end else if (n_magic_bad) begin
            n_status = ST_BAD_MAGIC;
        end else if (n_version_bad) begin
            n_status = ST_BAD_VER;
        end else if ({1'b0, n_source_word} >= r_source_limit) begin
            n_status = ST_BAD_SRC;
        end else if (n_rx_crc != n_running_crc) begin
            n_status = ST_BAD_CRC;
        end else begin
            n_status = ST_OK;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_magic    <= '0;
            r_schema_version <= '0;
            r_source_limit   <= SOURCE_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FRAME_MAGIC:    r_frame_magic    <= i_cfg_data[15:0];
                CFG_SCHEMA_VERSION: r_schema_version <= i_cfg_data[15:0];
                CFG_SOURCE_LIMIT:   r_source_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!blocked) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!blocked) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_end_of_buffer;
        end
    end

    // frame state, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_in_last)) begin
            r_byte_count  <= '0;
            r_running_crc <= CRC_INIT;
            r_high_hold   <= '0;
            r_magic_bad   <= 1'b0;
            r_version_bad <= 1'b0;
            r_source_word <= '0;
            r_seq_word    <= '0;
            r_time_word   <= '0;
            r_pos_x       <= '0;
            r_pos_y       <= '0;
            r_vel_x       <= '0;
            r_vel_y       <= '0;
            r_rx_crc      <= '0;
        end else if (fire) begin
            r_byte_count  <= n_byte_count;
            r_running_crc <= n_running_crc;
            r_high_hold   <= n_high_hold;
            r_magic_bad   <= n_magic_bad;
            r_version_bad <= n_version_bad;
            r_source_word <= n_source_word;
            r_seq_word    <= n_seq_word;
            r_time_word   <= n_time_word;
            r_pos_x       <= n_pos_x;
            r_pos_y       <= n_pos_y;
            r_vel_x       <= n_vel_x;
            r_vel_y       <= n_vel_y;
            r_rx_crc      <= n_rx_crc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_last) begin
            r_status <= n_status;
            if (n_status == ST_OK) begin
                r_out_source <= n_source_word;
                r_out_seq    <= n_seq_word;
                r_out_time   <= n_time_word;
                r_out_pos_x  <= n_pos_x;
                r_out_pos_y  <= n_pos_y;
                r_out_vel_x  <= n_vel_x;
                r_out_vel_y  <= n_vel_y;
            end else begin
                r_out_source <= '0;
                r_out_seq    <= '0;
                r_out_time   <= '0;
                r_out_pos_x  <= '0;
                r_out_pos_y  <= '0;
                r_out_vel_x  <= '0;
                r_out_vel_y  <= '0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_origin_id       = r_out_source;
    assign o_sequence_number = r_out_seq;
    assign o_time_ns         = $signed(r_out_time);
    assign o_position_x      = $signed(r_out_pos_x);
    assign o_position_y      = $signed(r_out_pos_y);
    assign o_velocity_x      = $signed(r_out_vel_x);
    assign o_velocity_y      = $signed(r_out_vel_y);

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// self-checking testbench for the record frame decoder unit
`timescale 1ns / 1ps

module tb;
    import rfd_pkg::*;

    localparam int FRAME_LEN   = FRAME_LENGTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 150;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] origin_id;
        logic [31:0] sequence_number;
        logic [63:0] time_ns;
        logic [31:0] position_x;
        logic [31:0] position_y;
        logic [31:0] velocity_x;
        logic [31:0] velocity_y;
    } t_record;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain;   // hold this word back until all results are in
    } t_byte_item;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MIN, FILL_MAX} t_fill;
    typedef enum int {
        K_GOOD, K_BAD_MAGIC, K_BAD_VERSION, K_BAD_SOURCE, K_BAD_CRC,
        K_SHORT, K_BIT_FLIP, K_NOISE, K_OVERLONG
    } t_frame_kind;
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_buffer = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [15:0] origin_id;
    logic [31:0] sequence_number;
    logic [63:0] time_ns;
    logic [31:0] position_x;
    logic [31:0] position_y;
    logic [31:0] velocity_x;
    logic [31:0] velocity_y;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_FRAME_MAGIC;
    logic [16:0] cfg_data = 17'd0;

    record_frame_decoder_unit DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_data_byte       (data_byte),
        .i_end_of_buffer   (end_of_buffer),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_status          (status),
        .o_origin_id       (origin_id),
        .o_sequence_number (sequence_number),
        .o_time_ns         (time_ns),
        .o_position_x      (position_x),
        .o_position_y      (position_y),
        .o_velocity_x      (velocity_x),
        .o_velocity_y      (velocity_y),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    t_byte_item pending_bytes[$];
    t_record    expected_records[$];
    int         errors = 0;

    // register copies, updated as each write is taken
    logic [15:0] reg_magic   = 16'h0000;
    logic [15:0] reg_version = 16'h0000;
    logic [16:0] reg_limit   = SOURCE_LIMIT_RST;

    // frame tracker state
    logic [5:0]  trk_count     = '0;
    logic [15:0] trk_crc       = CRC_INIT;
    logic [7:0]  trk_high      = '0;
    logic        trk_magic_bad = 1'b0;
    logic        trk_ver_bad   = 1'b0;
    logic [15:0] trk_source    = '0;
    logic [31:0] trk_sequence  = '0;
    logic [63:0] trk_time      = '0;
    logic [31:0] trk_pos_x     = '0;
    logic [31:0] trk_pos_y     = '0;
    logic [31:0] trk_vel_x     = '0;
    logic [31:0] trk_vel_y     = '0;
    logic [15:0] trk_rx_crc    = '0;

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s mismatch: got %h expected %h", name, got, want));
        end
    endtask

    // advance the frame tracker by one accepted word
    task automatic track_byte(input logic [7:0] b, input logic last);
        t_record rec;
        int      idx;
        idx = trk_count;
        if (idx < FRAME_LEN) begin
            if (idx < CRC_SPAN) begin
                trk_crc = crc16_next(trk_crc, b);
            end
            if (idx == 0 || idx == 2) begin
                trk_high = b;
            end else if (idx == 1) begin
                trk_magic_bad = ({trk_high, b} != reg_magic);
            end else if (idx == 3) begin
                trk_ver_bad = ({trk_high, b} != reg_version);
            end else if (idx <= 5) begin
                trk_source = {trk_source[7:0], b};
            end else if (idx >= 8 && idx <= 11) begin
                trk_sequence = {trk_sequence[23:0], b};
            end else if (idx >= 12 && idx <= 19) begin
                trk_time = {trk_time[55:0], b};
            end else if (idx >= 20 && idx <= 23) begin
                trk_pos_x = {trk_pos_x[23:0], b};
            end else if (idx >= 24 && idx <= 27) begin
                trk_pos_y = {trk_pos_y[23:0], b};
            end else if (idx >= 28 && idx <= 31) begin
                trk_vel_x = {trk_vel_x[23:0], b};
            end else if (idx >= 32 && idx <= 35) begin
                trk_vel_y = {trk_vel_y[23:0], b};
            end else if (idx == 36 || idx == 37) begin
                trk_rx_crc = {trk_rx_crc[7:0], b};
            end
        end
        if (trk_count != COUNT_MAX) begin
            trk_count++;
        end
        if (last) begin
            rec = '0;
            if (trk_count < FRAME_LEN) begin
                rec.status = ST_TRUNCATED;
            end else if (trk_magic_bad) begin
                rec.status = ST_BAD_MAGIC;
            end else if (trk_ver_bad) begin
                rec.status = ST_BAD_VER;
            end else if ({1'b0, trk_source} >= reg_limit) begin
                rec.status = ST_BAD_SRC;
            end else if (trk_rx_crc != trk_crc) begin
                rec.status = ST_BAD_CRC;
            end else begin
                rec.status          = ST_OK;
                rec.origin_id       = trk_source;
                rec.sequence_number = trk_sequence;
                rec.time_ns         = trk_time;
                rec.position_x      = trk_pos_x;
                rec.position_y      = trk_pos_y;
                rec.velocity_x      = trk_vel_x;
                rec.velocity_y      = trk_vel_y;
            end
            expected_records.push_back(rec);
            trk_count     = '0;
            trk_crc       = CRC_INIT;
            trk_high      = '0;
            trk_magic_bad = 1'b0;
            trk_ver_bad   = 1'b0;
            trk_source    = '0;
            trk_sequence  = '0;
            trk_time      = '0;
            trk_pos_x     = '0;
            trk_pos_y     = '0;
            trk_vel_x     = '0;
            trk_vel_y     = '0;
            trk_rx_crc    = '0;
        end
    endtask

    // byte sender: bursts of random length with random gaps
    int         burst_left = 0;
    int         gap_left = 0;
    t_byte_item head;
    logic       offer;

    always @(posedge clk) begin
        if (rst_n) begin
            offer = in_valid;
            if (in_valid && !in_stall) begin
                track_byte(data_byte, end_of_buffer);
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_bytes.size() > 0 &&
                             !(pending_bytes[0].drain && expected_records.size() > 0)) begin
                    head = pending_bytes.pop_front();
                    data_byte     <= head.data;
                    end_of_buffer <= head.last;
                    offer = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(3, 0) == 0) ? 300 : $urandom_range(40, 1);
                        gap_left   = $urandom_range(8, 1);
                    end
                end
            end
            in_valid <= offer;
        end
    end

    // result side stall pattern, with long hold-offs on request or at random
    int       hold_req = 0;
    int       hold_ack = 0;
    int       hold_left = 0;
    int       mode_left = 0;
    t_rx_mode rx_mode = RX_FREE;
    logic     stall_next;

    always @(posedge clk) begin
        if (rst_n) begin
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = LONG_HOLD;
            end else if (hold_left == 0 && $urandom_range(1499, 0) == 0) begin
                hold_left = $urandom_range(90, 30);
            end
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(3, 0));
                mode_left = $urandom_range(200, 20);
            end
            mode_left--;
            if (hold_left > 0) begin
                stall_next = 1'b1;
                hold_left--;
            end else begin
                case (rx_mode)
                    RX_FREE:  stall_next = 1'b0;
                    RX_LIGHT: stall_next = ($urandom_range(3, 0) == 0);
                    RX_HEAVY: stall_next = ($urandom_range(3, 0) != 0);
                    default:  stall_next = ((mode_left % 5) < 2);
                endcase
            end
            out_stall <= stall_next;
        end
    end

    // result checker
    t_record want;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_records.size() == 0) begin
                report_mismatch($sformatf("unexpected result with status %0d", status));
            end else begin
                want = expected_records.pop_front();
                check_field("status", status, want.status);
                check_field("origin_id", origin_id, want.origin_id);
                check_field("sequence_number", sequence_number, want.sequence_number);
                check_field("time_ns", time_ns, want.time_ns);
                check_field("position_x", position_x, want.position_x);
                check_field("position_y", position_y, want.position_y);
                check_field("velocity_x", velocity_x, want.velocity_x);
                check_field("velocity_y", velocity_y, want.velocity_y);
            end
        end
    end

    int cycles = 0;

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_FRAME_MAGIC:    reg_magic   = value[15:0];
            CFG_SCHEMA_VERSION: reg_version = value[15:0];
            CFG_SOURCE_LIMIT:   reg_limit   = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] magic, input logic [15:0] ver,
                              input logic [16:0] limit);
        write_reg(CFG_FRAME_MAGIC, {1'b0, magic});
        write_reg(CFG_SCHEMA_VERSION, {1'b0, ver});
        write_reg(CFG_SOURCE_LIMIT, limit);
        cfg_valid <= 1'b0;
    endtask

    // wait until everything sent has come back, then let the pipeline settle
    task automatic wait_idle();
        do @(posedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_records.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic queue_frame(input logic [15:0] magic, input logic [15:0] ver,
                               input logic [15:0] src, input int len, input bit crc_ok,
                               input t_fill fill, input bit flip, input bit drain);
        logic [7:0]  fb [128];
        logic [15:0] c;
        int          k;
        t_byte_item  it;
        for (int i = 0; i < 128; i++) begin
            case (fill)
                FILL_ZERO: fb[i] = 8'h00;
                FILL_ONES: fb[i] = 8'hFF;
                FILL_MIN:  fb[i] = 8'h00;
                FILL_MAX:  fb[i] = 8'hFF;
                default:   fb[i] = 8'($urandom);
            endcase
        end
        // top byte of each signed field sets its sign
        if (fill == FILL_MIN || fill == FILL_MAX) begin
            foreach (fb[i]) begin
                if (i == 12 || i == 20 || i == 24 || i == 28 || i == 32) begin
                    fb[i] = (fill == FILL_MIN) ? 8'h80 : 8'h7F;
                end
            end
        end
        fb[0] = magic[15:8];
        fb[1] = magic[7:0];
        fb[2] = ver[15:8];
        fb[3] = ver[7:0];
        fb[4] = src[15:8];
        fb[5] = src[7:0];
        c = CRC_INIT;
        for (int i = 0; i < 36; i++) begin
            c = crc16_next(c, fb[i]);
        end
        if (!crc_ok) begin
            c = c ^ (16'h0001 << $urandom_range(15, 0));
        end
        fb[36] = c[15:8];
        fb[37] = c[7:0];
        if (flip) begin
            k = $urandom_range(len - 1, 0);
            fb[k] = fb[k] ^ (8'h01 << $urandom_range(7, 0));
        end
        for (int i = 0; i < len; i++) begin
            it.data  = fb[i];
            it.last  = (i == len - 1);
            it.drain = drain && (i == 0);
            pending_bytes.push_back(it);
        end
    endtask

    task automatic queue_noise(input int n);
        t_byte_item it;
        for (int i = 0; i < n; i++) begin
            it.data  = 8'($urandom);
            it.last  = (i == n - 1) || ($urandom_range(15, 0) == 0);
            it.drain = 1'b0;
            pending_bytes.push_back(it);
        end
    endtask

    task automatic random_phase(input int n_bytes);
        logic [15:0] magic;
        logic [15:0] ver;
        logic [15:0] src;
        int          limit;
        int          sent;
        int          len;
        int          pick;
        bit          drain;
        t_frame_kind kind;
        magic = 16'($urandom);
        ver   = 16'($urandom);
        case ($urandom_range(5, 0))
            0:       limit = 0;
            1:       limit = SOURCE_LIMIT_RST;
            2:       limit = 65535;
            3:       limit = 1;
            default: limit = $urandom_range(65536, 0);
        endcase
        set_config(magic, ver, 17'(limit));
        // short buffers while the result side holds off, so the input backs up
        hold_req <= hold_req + 1;
        for (int i = 0; i < 30; i++) begin
            queue_noise($urandom_range(3, 1));
        end
        sent  = 0;
        drain = 1'b1;
        while (sent < n_bytes) begin
            pick = $urandom_range(18, 0);
            kind = (pick < 11) ? K_GOOD : t_frame_kind'(pick - 10);
            if (limit == 0 || limit > 65535) begin
                src = 16'($urandom);
            end else begin
                src = 16'($urandom_range(limit - 1, 0));
            end
            len = FRAME_LEN;
            if ($urandom_range(4, 0) == 0) begin
                len = $urandom_range(70, FRAME_LEN + 1);
            end
            case (kind)
                K_BAD_MAGIC: queue_frame(magic ^ (16'h0001 << $urandom_range(15, 0)), ver,
                                         src, len, 1, FILL_RANDOM, 0, drain);
                K_BAD_VERSION: queue_frame(magic, ver ^ (16'h0001 << $urandom_range(15, 0)),
                                           src, len, 1, FILL_RANDOM, 0, drain);
                K_BAD_SOURCE: begin
                    if (limit <= 65535) begin
                        src = 16'($urandom_range(65535, limit));
                    end
                    queue_frame(magic, ver, src, len, 1, FILL_RANDOM, 0, drain);
                end
                K_BAD_CRC: queue_frame(magic, ver, src, len, 0, FILL_RANDOM, 0, drain);
                K_SHORT: begin
                    len = $urandom_range(FRAME_LEN - 1, 1);
                    queue_frame(magic, ver, src, len, 1, FILL_RANDOM, 0, drain);
                end
                K_BIT_FLIP: queue_frame(magic, ver, src, len, 1, FILL_RANDOM, 1, drain);
                K_NOISE: begin
                    len = $urandom_range(50, 1);
                    queue_noise(len);
                end
                K_OVERLONG: begin
                    len = $urandom_range(100, 64);
                    queue_frame(magic, ver, src, len, 1, FILL_RANDOM, 0, drain);
                end
                default: queue_frame(magic, ver, src, len, 1, FILL_RANDOM, 0, drain);
            endcase
            sent += len;
            drain = ($urandom_range(19, 0) == 0);
        end
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: zero magic and version, every source id accepted
        queue_frame(16'h0000, 16'h0000, 16'hFFFF, FRAME_LEN, 1, FILL_ZERO, 0, 0);
        queue_frame(16'h0000, 16'h0000, 16'hFFFF, FRAME_LEN, 1, FILL_ONES, 0, 0);
        queue_noise(1);
        queue_frame(16'h0000, 16'h0000, 16'h0000, FRAME_LEN - 1, 1, FILL_RANDOM, 0, 0);
        wait_idle();

        // a zero limit rejects every source
        set_config(16'hFFFF, 16'hFFFF, 17'd0);
        queue_frame(16'hFFFF, 16'hFFFF, 16'h0000, FRAME_LEN, 1, FILL_RANDOM, 0, 0);
        queue_frame(16'hFFFF, 16'h0000, 16'h0000, FRAME_LEN, 1, FILL_RANDOM, 0, 0);
        // truncation hides a bad magic
        queue_frame(16'h0000, 16'h0000, 16'h0000, FRAME_LEN - 1, 0, FILL_RANDOM, 0, 0);
        wait_idle();

        set_config(16'hA5C3, 16'h0102, 17'h01234);
        queue_frame(16'hA5C3, 16'h0102, 16'h1233, FRAME_LEN, 1, FILL_MIN, 0, 0);
        queue_frame(16'hA5C3, 16'h0102, 16'h1234, FRAME_LEN, 1, FILL_RANDOM, 0, 0);
        queue_frame(16'hA5C3, 16'h0102, 16'h0000, FRAME_LEN, 1, FILL_MAX, 0, 0);
        queue_frame(16'h5AC3, 16'h0103, 16'hFFFF, FRAME_LEN, 0, FILL_RANDOM, 0, 0);
        queue_frame(16'hA5C3, 16'h0103, 16'hFFFF, FRAME_LEN, 1, FILL_RANDOM, 0, 0);
        queue_frame(16'hA5C3, 16'h0102, 16'h8000, FRAME_LEN, 0, FILL_RANDOM, 0, 0);
        queue_frame(16'hA5C3, 16'h0102, 16'h0042, FRAME_LEN, 0, FILL_RANDOM, 0, 0);
        queue_frame(16'hA5C3, 16'h0102, 16'h0001, FRAME_LEN + 1, 1, FILL_RANDOM, 0, 0);
        queue_frame(16'hA5C3, 16'h0102, 16'h0002, 63, 1, FILL_RANDOM, 0, 0);
        // byte count saturates past 63
        queue_frame(16'hA5C3, 16'h0102, 16'h0003, 64, 1, FILL_RANDOM, 0, 0);
        queue_frame(16'hA5C3, 16'h0102, 16'h0004, 100, 1, FILL_RANDOM, 0, 0);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            random_phase(250);
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
